@@ rtl/sat_pkg.sv @@
package sat_pkg;

	localparam int MAX_RESULTS = 16;

	localparam logic [1:0] REG_MODULUS = 2'd0;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_SET  = 2'd1,
		ACT_DEL  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_SET  = 2'd0,
		KIND_DEL  = 2'd1,
		KIND_FIRE = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRD,
		ST_DWR,
		ST_ERD,
		ST_EWAIT,
		ST_MSTART,
		ST_MOD,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic        we;
		logic        re;
		logic        out_load;
	} ctl_t;

endpackage

@@ rtl/sat_mem.sv @@
module sat_mem import sat_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 80,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/sat_mod_unit.sv @@
module sat_mod_unit import sat_pkg::*; #(
	parameter int TB = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [TB-1:0] dividend,
	input  logic [31:0]   modulus,
	output logic          done,
	output logic [31:0]   result
);

	localparam int CNTW = $clog2(TB + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [TB-1:0]   dvd_q;
	logic [31:0]     rem_q;
	logic [32:0]     sh;
	logic [32:0]     rem_n;

	assign sh    = {rem_q, dvd_q[TB-1]};
	assign rem_n = (sh >= {1'b0, modulus}) ? sh - {1'b0, modulus} : sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(TB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_n[31:0];
		end
	end

	assign done   = done_q;
	assign result = (modulus == 32'd0) ? 32'd0 : rem_q;

endmodule

@@ rtl/software_alarm_table.sv @@
// set: accepted, then entries are scanned in order for a free row; when the
//   next fire count moves, the remainder unit runs, then the reply register loads
// delete: goes straight to the reply register; tick without dispatch: stays idle
// dispatch: an update pass (read, write) over the used rows, a result pass (read,
//   wait, which stalls on the output) over the same rows, then the remainder unit
// reset: asynchronous, clears all entries to free; entry memory needs no clearing
module software_alarm_table import sat_pkg::*; #(
	parameter int NUM_ENTRIES = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [15:0] timer_id,
	input  logic [31:0] delay,
	input  logic [31:0] period,
	input  logic [3:0]  handle,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  kind,
	output logic [3:0]  entry,
	output logic        entry_valid,
	output logic [15:0] fired_id,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NE = NUM_ENTRIES;
	localparam int TB = TIME_BITS;
	localparam int IW = (NE > 1) ? $clog2(NE) : 1;
	localparam int CW = $clog2(NE + 1);
	localparam int WW = 16 + 2 * TB;
	localparam logic [TB-1:0] TMASK = '1;

	state_t          state_q, state_d;
	ctl_t            ctl;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   count_q;
	logic [NE-1:0]   armed_q;
	logic [NE-1:0]   fired_q;
	logic [TB-1:0]   sleep_q;
	logic [TB-1:0]   wake_q;
	logic [31:0]     tick_q;
	logic [31:0]     nfc_q;
	logic [31:0]     lastd_q;
	logic [31:0]     modulus_q;
	logic [TB-1:0]   mod_arg_q;
	logic            reply_pend_q;
	logic [4:0]      nres_q;
	logic [15:0]     id_q;
	logic [TB-1:0]   val_q;
	logic [TB-1:0]   per_q;
	logic [1:0]      rp_kind_q;
	logic [3:0]      rp_entry_q;
	logic            rp_valid_q;

	logic            rsp_valid_q;
	logic [1:0]      kind_q;
	logic [3:0]      entry_q;
	logic            entry_valid_q;
	logic [15:0]     fired_id_q;
	logic            last_q;

	logic            accept;
	logic            out_free;
	logic [31:0]     tick_inc;
	logic [31:0]     tick_n;
	logic            disp;
	logic            is_free;
	logic            scan_end;
	logic            last_row;
	logic [31:0]     diff;
	logic [TB-1:0]   el;
	logic            set_short;
	logic [WW-1:0]   rdata;
	logic [WW-1:0]   wdata;
	logic [15:0]     rd_ident;
	logic [TB-1:0]   rd_reload;
	logic [TB-1:0]   rd_rem;
	logic            rd_fire;
	logic [TB-1:0]   new_rem;
	logic [TB-1:0]   wake_n;
	logic [NE-1:0]   hi_mask;
	logic            any_higher;
	logic            emit;
	logic            mod_done;
	logic [31:0]     mod_res;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign tick_inc = tick_q + 32'd1;
	assign tick_n   = (tick_inc >= modulus_q) ? 32'd0 : tick_inc;
	assign disp     = (tick_n == nfc_q);

	assign is_free  = !armed_q[idx_q];
	assign scan_end = (CW'(idx_q) == count_q) || (idx_q == IW'(NE - 1));
	assign last_row = (CW'(idx_q) + CW'(1) == count_q);

	assign diff      = (tick_q > lastd_q) ? tick_q - lastd_q : lastd_q - tick_q;
	assign el        = TB'(diff);
	assign set_short = (sleep_q > el) && (sleep_q - el > val_q);

	assign rd_ident  = rdata[WW-1 -: 16];
	assign rd_reload = rdata[2*TB-1 -: TB];
	assign rd_rem    = rdata[TB-1:0];
	assign rd_fire   = armed_q[idx_q] && (rd_rem <= sleep_q);
	assign new_rem   = rd_fire ? rd_reload : rd_rem - sleep_q;

	always_comb begin
		wake_n = wake_q;
		if (armed_q[idx_q] && !(rd_fire && rd_reload == '0) && new_rem < wake_q) begin
			wake_n = new_rem;
		end
	end

	always_comb begin
		for (int j = 0; j < NE; j++) begin
			hi_mask[j] = (j > int'(idx_q));
		end
	end
	assign any_higher = |(fired_q & hi_mask);
	assign emit = fired_q[idx_q] && (nres_q < 5'(MAX_RESULTS));

	assign wdata = (state_q == ST_SCAN) ? {id_q, per_q, val_q + el}
	                                    : {rd_ident, rd_reload, new_rem};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_SET:  state_d = ST_SCAN;
						ACT_DEL:  state_d = ST_REPLY;
						ACT_TICK: begin
							if (disp) begin
								state_d = (count_q == '0) ? ST_MSTART : ST_DRD;
							end
						end
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (is_free) begin
					state_d = set_short ? ST_MSTART : ST_REPLY;
				end else if (scan_end) begin
					state_d = ST_REPLY;
				end
			end
			ST_DRD:    state_d = ST_DWR;
			ST_DWR:    state_d = last_row ? ST_ERD : ST_DRD;
			ST_ERD:    state_d = ST_EWAIT;
			ST_EWAIT: begin
				if (!emit || out_free) begin
					state_d = last_row ? ST_MSTART : ST_ERD;
				end
			end
			ST_MSTART: state_d = ST_MOD;
			ST_MOD: begin
				if (mod_done) begin
					state_d = reply_pend_q ? ST_REPLY : ST_IDLE;
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_SCAN:  ctl.we = is_free;
			ST_DRD:   ctl.re = 1'b1;
			ST_DWR:   ctl.we = armed_q[idx_q];
			ST_ERD:   ctl.re = 1'b1;
			ST_EWAIT: ctl.out_load = emit && out_free;
			ST_REPLY: ctl.out_load = out_free;
			default:  ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			armed_q      <= '0;
			fired_q      <= '0;
			sleep_q      <= TMASK;
			tick_q       <= '0;
			nfc_q        <= '0;
			lastd_q      <= '0;
			modulus_q    <= 32'd65535;
			reply_pend_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr == REG_MODULUS) begin
				modulus_q <= pwdata;
			end
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						reply_pend_q <= (action == ACT_SET) || (action == ACT_DEL);
						case (action)
							ACT_DEL: begin
								if (count_q != '0 && 8'(handle) + 8'd1 == 8'(count_q)) begin
									count_q <= count_q - CW'(1);
								end
								if (8'(handle) < 8'(NE)) begin
									armed_q[IW'(handle)] <= 1'b0;
								end
							end
							ACT_TICK: begin
								tick_q <= tick_n;
								if (disp) begin
									lastd_q <= tick_n;
									fired_q <= '0;
									if (count_q == '0) begin
										sleep_q <= TMASK;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (is_free) begin
						armed_q[idx_q] <= 1'b1;
						if (CW'(idx_q) == count_q) begin
							count_q <= count_q + CW'(1);
						end
						if (set_short) begin
							sleep_q <= el + val_q;
						end
					end
				end
				ST_DWR: begin
					if (rd_fire) begin
						fired_q[idx_q] <= 1'b1;
						if (rd_reload == '0) begin
							armed_q[idx_q] <= 1'b0;
						end
					end
					if (last_row) begin
						sleep_q <= wake_n;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						nfc_q <= mod_res;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q  <= '0;
				nres_q <= '0;
				wake_q <= TMASK;
				id_q   <= timer_id;
				val_q  <= TB'(delay);
				per_q  <= TB'(period);
				rp_kind_q  <= KIND_DEL;
				rp_entry_q <= handle;
				rp_valid_q <= 1'b0;
				if (action == ACT_TICK) begin
					mod_arg_q <= TB'(tick_n) + TMASK;
				end
			end
			ST_SCAN: begin
				rp_kind_q <= KIND_SET;
				if (is_free) begin
					rp_entry_q <= 4'(idx_q);
					rp_valid_q <= 1'b1;
					mod_arg_q  <= TB'(tick_q) + val_q;
				end else if (scan_end) begin
					rp_entry_q <= 4'd0;
					rp_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			ST_DWR: begin
				wake_q <= wake_n;
				if (last_row) begin
					idx_q     <= '0;
					mod_arg_q <= TB'(tick_q) + wake_n;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			ST_EWAIT: begin
				if (!emit || out_free) begin
					if (!last_row) begin
						idx_q <= idx_q + IW'(1);
					end
					if (emit) begin
						nres_q <= nres_q + 5'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			if (state_q == ST_EWAIT) begin
				kind_q        <= KIND_FIRE;
				entry_q       <= 4'(idx_q);
				entry_valid_q <= 1'b1;
				fired_id_q    <= rd_ident;
				last_q        <= !any_higher || (nres_q == 5'(MAX_RESULTS - 1));
			end else begin
				kind_q        <= rp_kind_q;
				entry_q       <= rp_entry_q;
				entry_valid_q <= rp_valid_q;
				fired_id_q    <= 16'd0;
				last_q        <= 1'b1;
			end
		end
	end

	sat_mem #(
		.DEPTH(NE),
		.WIDTH(WW),
		.AW(IW)
	) u_mem (
		.clk(clk),
		.we(ctl.we),
		.waddr(idx_q),
		.wdata(wdata),
		.re(ctl.re),
		.raddr(idx_q),
		.rdata(rdata)
	);

	sat_mod_unit #(
		.TB(TB)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_MSTART),
		.dividend(mod_arg_q),
		.modulus(modulus_q),
		.done(mod_done),
		.result(mod_res)
	);

	assign rsp_valid   = rsp_valid_q;
	assign kind        = kind_q;
	assign entry       = entry_q;
	assign entry_valid = entry_valid_q;
	assign fired_id    = fired_id_q;
	assign last        = last_q;
	assign prdata      = modulus_q;
	assign pready      = 1'b1;

endmodule

@@ verif/tb_software_alarm_table.sv @@
module tb_software_alarm_table;
	import sat_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int N = 16;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  entry;
		logic        ev;
		logic [15:0] id;
		logic        last;
	} alarm_rsp_t;

	class alarm_scoreboard;
		logic [31:0] modulus;
		bit          armed [N];
		logic [15:0] ident [N];
		logic [31:0] remaining [N];
		logic [31:0] reload [N];
		int          top;
		logic [31:0] span;
		logic [31:0] ticks;
		logic [31:0] next_fire;
		logic [31:0] last_disp;
		alarm_rsp_t  pending [$];
		int          errors;

		function new();
			modulus = 32'd65535;
			foreach (armed[i]) armed[i] = 0;
			top = -1;
			span = '1;
			ticks = 0;
			next_fire = 0;
			last_disp = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void push(logic [1:0] k, logic [3:0] e, logic v, logic [15:0] id, logic l);
			alarm_rsp_t r;
			r.kind = k;
			r.entry = e;
			r.ev = v;
			r.id = id;
			r.last = l;
			pending.push_back(r);
		endfunction

		function void arm_fire(logic [31:0] s);
			logic [31:0] sum;
			sum = ticks + s;
			next_fire = (modulus == 0) ? 32'd0 : sum % modulus;
		endfunction

		function void dispatch();
			bit          hit [N];
			logic [31:0] wake;
			int          n;
			int          lastpos;
			wake = '1;
			n = 0;
			for (int i = 0; i <= top && i < N; i++) begin
				hit[i] = 0;
				if (!armed[i])
					continue;
				if (remaining[i] <= span) begin
					hit[i] = 1;
					if (reload[i] == 0) begin
						armed[i] = 0;
					end else begin
						remaining[i] = reload[i];
						if (remaining[i] < wake)
							wake = remaining[i];
					end
				end else begin
					remaining[i] = remaining[i] - span;
					if (remaining[i] < wake)
						wake = remaining[i];
				end
			end
			span = wake;
			arm_fire(wake);
			for (int i = 0; i <= top && i < N; i++) begin
				if (hit[i] && n < MAX_RESULTS) begin
					push(KIND_FIRE, i[3:0], 1'b1, ident[i], 1'b0);
					n++;
				end
			end
			if (n > 0) begin
				lastpos = pending.size() - 1;
				pending[lastpos].last = 1'b1;
			end
		endfunction

		function void note(logic [1:0] act, logic [15:0] id, logic [31:0] dly,
				logic [31:0] per, logic [3:0] hnd);
			logic [31:0] el;
			int          row;
			el = (ticks > last_disp) ? ticks - last_disp : last_disp - ticks;
			case (act)
				ACT_SET: begin
					row = -1;
					for (int i = 0; i <= top + 1 && i < N; i++) begin
						if (!armed[i]) begin
							row = i;
							break;
						end
					end
					if (row < 0) begin
						push(KIND_SET, 4'd0, 1'b0, 16'd0, 1'b1);
					end else begin
						if (row == top + 1)
							top++;
						if (span > el && span - el > dly) begin
							span = el + dly;
							arm_fire(dly);
						end
						ident[row] = id;
						remaining[row] = dly + el;
						reload[row] = per;
						armed[row] = 1;
						push(KIND_SET, row[3:0], 1'b1, 16'd0, 1'b1);
					end
				end
				ACT_DEL: begin
					if (int'(hnd) == top)
						top--;
					armed[hnd] = 0;
					push(KIND_DEL, hnd, 1'b0, 16'd0, 1'b1);
				end
				ACT_TICK: begin
					ticks = ticks + 32'd1;
					if (ticks >= modulus)
						ticks = 0;
					if (ticks == next_fire) begin
						last_disp = ticks;
						dispatch();
					end
				end
				default: ;
			endcase
		endfunction

		task check(alarm_rsp_t got);
			alarm_rsp_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected response kind %0d entry %0d", got.kind, got.entry));
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.entry !== want.entry)
				report($sformatf("entry %0d, want %0d", got.entry, want.entry));
			if (got.ev !== want.ev)
				report($sformatf("entry_valid %0d, want %0d", got.ev, want.ev));
			if (got.id !== want.id)
				report($sformatf("fired_id %0h, want %0h", got.id, want.id));
			if (got.last !== want.last)
				report($sformatf("last %0d, want %0d", got.last, want.last));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_stall;
	logic [1:0]  action = ACT_TICK;
	logic [15:0] timer_id = 0;
	logic [31:0] delay = 0;
	logic [31:0] period = 0;
	logic [3:0]  handle = 0;
	logic        rsp_valid;
	logic        rsp_stall = 0;
	logic [1:0]  kind;
	logic [3:0]  entry;
	logic        entry_valid;
	logic [15:0] fired_id;
	logic        last;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [1:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	alarm_scoreboard alarms = new();
	int send_idle = 0;
	int recv_stall = 0;

	software_alarm_table i_dut (.*);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		alarm_rsp_t got;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.kind = kind;
			got.entry = entry;
			got.ev = entry_valid;
			got.id = fired_id;
			got.last = last;
			alarms.check(got);
		end
	end

	task send(logic [1:0] act, logic [15:0] id, logic [31:0] dly, logic [31:0] per,
			logic [3:0] hnd);
		if ($urandom_range(99) < send_idle) begin
			req_valid = 0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		action = act;
		timer_id = id;
		delay = dly;
		period = per;
		handle = hnd;
		req_valid = 1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		alarms.note(act, id, dly, per, hnd);
		@(negedge clk);
	endtask

	task write_modulus(logic [31:0] val);
		psel = 1;
		pwrite = 1;
		paddr = REG_MODULUS;
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		alarms.modulus = val;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task drain();
		req_valid = 0;
		while (alarms.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task random_item();
		int          r;
		logic [31:0] dly;
		logic [31:0] per;
		r = $urandom_range(99);
		if ($urandom_range(9) < 8)
			dly = $urandom_range(12);
		else if ($urandom_range(1) == 0)
			dly = $urandom_range(1000);
		else
			dly = $urandom;
		case ($urandom_range(4))
			0, 1: per = 0;
			2, 3: per = $urandom_range(1, 15);
			default: per = $urandom;
		endcase
		if (r < 55)
			send(ACT_TICK, 16'($urandom), $urandom, $urandom, 4'($urandom));
		else if (r < 82)
			send(ACT_SET, 16'($urandom), dly, per, 4'($urandom));
		else if (r < 96)
			send(ACT_DEL, 16'($urandom), $urandom, $urandom, 4'($urandom));
		else
			send(ACT_UNUSED, 16'($urandom), $urandom, $urandom, 4'($urandom));
	endtask

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [31:0] moduli [5];
		int          sidle [5];
		int          rstall [5];
		moduli = '{32'd65535, 32'd1, 32'd7, 32'hFFFF_FFFF, 32'd0};
		sidle = '{0, 72, 0, 6, 0};
		rstall = '{0, 0, 72, 6, 0};
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// fill the table, overflow it, then tick and free entries
		send(ACT_SET, 16'h0000, 32'd0, 32'd0, 4'd0);
		send(ACT_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		for (int i = 2; i < N; i++)
			send(ACT_SET, 16'(i * 16'h1111), 32'(i), (i % 2) ? 32'd3 : 32'd0, 4'd0);
		send(ACT_SET, 16'hABCD, 32'd1, 32'd0, 4'd0);
		send(ACT_UNUSED, 16'hFFFF, '1, '1, 4'hF);
		repeat (4) send(ACT_TICK, 16'd0, 32'd0, 32'd0, 4'd0);
		send(ACT_DEL, 16'd0, 32'd0, 32'd0, 4'd15);
		send(ACT_DEL, 16'd0, 32'd0, 32'd0, 4'd1);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_modulus(moduli[ph]);
			send_idle = sidle[ph];
			recv_stall = rstall[ph];
			for (int k = 0; k < 20; k++)
				random_item();
			for (int h = 0; h < N; h++)
				if ($urandom_range(1) == 0)
					send(ACT_DEL, 16'($urandom), $urandom, $urandom, 4'(h));
			drain();
		end
		recv_stall = 0;

		if (alarms.errors == 0 && alarms.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
